FILE: sv/msp_pkg.sv
// shared types and constants of the midi stream parser
// no dependencies; used by msp_decode and midi_stream_parser_top
`default_nettype none

package msp_pkg;

    // event codes on the kind field
    typedef enum logic [3:0] {
        KIND_NOTEOFF   = 4'd0,
        KIND_NOTEON    = 4'd1,
        KIND_POLYPRESS = 4'd2,
        KIND_CC        = 4'd3,
        KIND_PROGRAM   = 4'd4,
        KIND_CHANPRESS = 4'd5,
        KIND_BEND      = 4'd6,
        KIND_REALTIME  = 4'd7,
        KIND_COMMON    = 4'd8,
        KIND_SYSEX     = 4'd9
    } msp_kind_t;

    // status byte values
    localparam logic [7:0] REALTIME_FIRST = 8'hF8;
    localparam logic [7:0] SYSEX_START    = 8'hF0;
    localparam logic [7:0] SYSEX_END      = 8'hF7;

    // high nibble of a status byte
    localparam logic [3:0] TYPE_NOTEOFF   = 4'h8;
    localparam logic [3:0] TYPE_NOTEON    = 4'h9;
    localparam logic [3:0] TYPE_POLYPRESS = 4'hA;
    localparam logic [3:0] TYPE_CC        = 4'hB;
    localparam logic [3:0] TYPE_PROGRAM   = 4'hC;
    localparam logic [3:0] TYPE_CHANPRESS = 4'hD;
    localparam logic [3:0] TYPE_BEND      = 4'hE;
    localparam logic [3:0] TYPE_SYSTEM    = 4'hF;

    // parse state carried from byte to byte
    typedef struct packed {
        logic [7:0] running_status;
        logic [6:0] pending_data;
        logic       pending_valid;
        logic       in_sysex;
    } msp_state_t;

    // one decoded event
    typedef struct packed {
        msp_kind_t   kind;
        logic [3:0]  channel;
        logic [6:0]  first_value;
        logic [6:0]  second_value;
        logic [13:0] bend_value;
        logic [7:0]  raw_byte;
        logic        sysex_last;
    } msp_result_t;

endpackage

`default_nettype wire

FILE: sv/msp_decode.sv
// per-byte decode: next parse state and at most one event
// depends on msp_pkg
`default_nettype none

module msp_decode
    import msp_pkg::*;
(
    input  wire logic [7:0]  midi_byte,
    input  wire msp_state_t  state,
    output msp_state_t       state_next,
    output logic             result_valid,
    output msp_result_t      result
);

    logic [3:0] status_type;
    logic [3:0] status_chan;

    assign status_type = state.running_status[7:4];
    assign status_chan = state.running_status[3:0];

    always_comb
    begin
        state_next   = state;
        result_valid = 1'b0;
        result       = '0;

        if (midi_byte >= REALTIME_FIRST)
        begin
            // real-time leaves the parse state alone
            result_valid    = 1'b1;
            result.kind     = KIND_REALTIME;
            result.raw_byte = midi_byte;
        end
        else if (midi_byte[7])
        begin
            state_next.pending_valid = 1'b0;
            state_next.pending_data  = '0;
            state_next.in_sysex      = 1'b0;
            if (midi_byte[7:4] == TYPE_SYSTEM)
            begin
                state_next.running_status = '0;
                result_valid    = 1'b1;
                result.raw_byte = midi_byte;
                if (midi_byte == SYSEX_START)
                begin
                    state_next.in_sysex = 1'b1;
                    result.kind         = KIND_SYSEX;
                end
                else if (midi_byte == SYSEX_END && state.in_sysex)
                begin
                    result.kind       = KIND_SYSEX;
                    result.sysex_last = 1'b1;
                end
                else
                begin
                    result.kind = KIND_COMMON;
                end
            end
            else
            begin
                state_next.running_status = midi_byte;
            end
        end
        else if (state.in_sysex)
        begin
            result_valid    = 1'b1;
            result.kind     = KIND_SYSEX;
            result.raw_byte = midi_byte;
        end
        else if (state.running_status[7] && status_type != TYPE_SYSTEM)
        begin
            result.channel = status_chan;
            if (status_type == TYPE_PROGRAM || status_type == TYPE_CHANPRESS)
            begin
                result_valid       = 1'b1;
                result.kind        = (status_type == TYPE_PROGRAM) ? KIND_PROGRAM
                                                                   : KIND_CHANPRESS;
                result.first_value = midi_byte[6:0];
            end
            else if (!state.pending_valid)
            begin
                // hold the first data byte
                state_next.pending_data  = midi_byte[6:0];
                state_next.pending_valid = 1'b1;
            end
            else
            begin
                state_next.pending_data  = '0;
                state_next.pending_valid = 1'b0;
                result_valid             = 1'b1;
                result.first_value       = state.pending_data;
                result.second_value      = midi_byte[6:0];
                case (status_type)
                    TYPE_NOTEOFF:   result.kind = KIND_NOTEOFF;
                    TYPE_NOTEON:    result.kind = (midi_byte[6:0] == 7'd0) ? KIND_NOTEOFF
                                                                          : KIND_NOTEON;
                    TYPE_POLYPRESS: result.kind = KIND_POLYPRESS;
                    TYPE_CC:        result.kind = KIND_CC;
                    default:
                    begin
                        // pitch bend, second byte is the high half
                        result.kind         = KIND_BEND;
                        result.first_value  = '0;
                        result.second_value = '0;
                        result.bend_value   = {midi_byte[6:0], state.pending_data};
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/midi_stream_parser_top.sv
// top level of the midi stream parser: input register, decode, result register with skid
// depends on msp_pkg and msp_decode
//
//  port group      | direction | handshake          | payload
//  ----------------+-----------+--------------------+--------------------------------------
//  byte in         | in        | in_valid/in_stall  | midi_byte
//  event out       | out       | out_valid/out_stall| kind, channel, first_value,
//                  |           |                    | second_value, bend_value, raw_byte,
//                  |           |                    | sysex_last
//
// one byte per cycle sustained while in_stall is low; an event passes the input register,
// then decode into the result register, or into the skid register while the result is held
// bytes that end in no event (status, first data byte, dropped data) only update the state
// rst_n clears the parse state and all valid flags asynchronously
// a skid register behind the result register absorbs one event while out_stall is high,
// so in_stall comes from flops only and never from out_stall directly
`default_nettype none

module midi_stream_parser_top
    import msp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  midi_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       kind,
    output logic [3:0]       channel,
    output logic [6:0]       first_value,
    output logic [6:0]       second_value,
    output logic [13:0]      bend_value,
    output logic [7:0]       raw_byte,
    output logic             sysex_last
);

    // input register
    logic        byte_valid_reg;
    logic [7:0]  byte_reg;

    // parse state
    msp_state_t  state_reg;
    msp_state_t  state_next;

    // result register and skid
    logic        out_valid_reg;
    msp_result_t out_reg;
    logic        skid_valid_reg;
    msp_result_t skid_reg;

    logic        dec_valid;
    msp_result_t dec_result;
    logic        consume;
    logic        fire;
    logic        pop;
    logic        take_in;

    msp_decode u_decode (
        .midi_byte    (byte_reg),
        .state        (state_reg),
        .state_next   (state_next),
        .result_valid (dec_valid),
        .result       (dec_result)
    );

    // the buffered byte is decoded whenever the skid is free
    assign consume  = byte_valid_reg && !skid_valid_reg;
    assign fire     = consume && dec_valid;
    assign pop      = out_valid_reg && !out_stall;
    assign in_stall = byte_valid_reg && skid_valid_reg;
    assign take_in  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            state_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                byte_valid_reg <= in_valid;
            end
            if (consume)
            begin
                state_reg <= state_next;
            end
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (fire)
            begin
                if (out_valid_reg && !pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            byte_reg <= midi_byte;
        end
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (fire)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= dec_result;
            end
            else
            begin
                out_reg <= dec_result;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign channel      = out_reg.channel;
    assign first_value  = out_reg.first_value;
    assign second_value = out_reg.second_value;
    assign bend_value   = out_reg.bend_value;
    assign raw_byte     = out_reg.raw_byte;
    assign sysex_last   = out_reg.sysex_last;

    // skid only ever fills behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an event while the result register is empty");

    // an open sysex run never keeps a channel status
    a_sysex_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.in_sysex |-> (state_reg.running_status == 8'd0))
        else $error("running status held during sysex");

    // end mark only on sysex events
    a_last_is_sysex: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.sysex_last) |-> (out_reg.kind == KIND_SYSEX))
        else $error("sysex_last on a non-sysex event");

    // bend carries its value only in bend_value
    a_bend_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_BEND)
            |-> (out_reg.first_value == 7'd0 && out_reg.second_value == 7'd0))
        else $error("bend event with nonzero data fields");

endmodule

`default_nettype wire
